### design/dq_pkg.sv
// Package for the double-ended queue: request codes, cell commands and widths.
package dq_pkg;

    localparam int WORD_W        = 32;
    localparam int DEPTH_DEFAULT = 16;

    typedef enum logic [1:0] {
        KIND_PUSH_FRONT = 2'd0,
        KIND_POP_FRONT  = 2'd1,
        KIND_PUSH_REAR  = 2'd2,
        KIND_POP_REAR   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHIFT_BACK,
        CELL_SHIFT_FORWARD,
        CELL_WRITE_TAIL,
        CELL_DROP_TAIL
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [WORD_W-1:0]   word;
    } cell_cmd_t;

endpackage

### design/dq_cell.sv
// One storage cell of the queue chain: a word, its valid bit and the tail tap.
module dq_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  dq_pkg::cell_cmd_t         cmd,
    input  logic [dq_pkg::WORD_W-1:0] left_data,
    input  logic                      left_valid,
    input  logic [dq_pkg::WORD_W-1:0] right_data,
    input  logic                      right_valid,
    output logic [dq_pkg::WORD_W-1:0] data,
    output logic                      valid,
    output logic [dq_pkg::WORD_W-1:0] tail_data
);
    import dq_pkg::*;

    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] data_next;
    logic              valid_reg;
    logic              valid_next;
    logic              is_tail;

    // The tail is the last occupied cell; the one after it is free.
    assign is_tail = valid_reg && !right_valid;

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        unique case (cmd.op)
            CELL_HOLD:
            begin
            end
            CELL_SHIFT_BACK:
            begin
                data_next  = left_data;
                valid_next = left_valid;
            end
            CELL_SHIFT_FORWARD:
            begin
                data_next  = right_data;
                valid_next = right_valid;
            end
            CELL_WRITE_TAIL:
            begin
                if (!valid_reg && left_valid)
                begin
                    data_next  = cmd.word;
                    valid_next = 1'b1;
                end
            end
            CELL_DROP_TAIL:
            begin
                if (is_tail)
                begin
                    valid_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign data      = data_reg;
    assign valid     = valid_reg;
    assign tail_data = is_tail ? data_reg : '0;

endmodule

### design/double_ended_queue_top.sv
// Top level of the double-ended queue built as a chain of storage cells.
//
// Requests arrive on the input channel (in_valid, in_stall, kind, value):
// push front, pop front, push rear or pop rear. Each accepted request gives
// exactly one result word on the output channel (out_valid, out_stall,
// popped, was_empty, was_full, count) in the next cycle, from an output
// register. A new request is taken in every cycle while the result side
// keeps up, so throughput is one request per cycle. The front of the queue
// always sits in the first cell: a push or pop at the front shifts every
// cell by one place in the same cycle, while the rear is found from each
// cell's own neighbour bits and read through an OR over the cells. A pop
// from an empty queue returns 0 with was_empty set; a push into a full
// queue is dropped with was_full set. Reset clears every valid bit and the
// count, so the queue starts empty and ready at once. While the receiver
// stalls a waiting result, in_stall is raised and no further request is
// taken until the result has gone.
module double_ended_queue_top #(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  dq_pkg::kind_t                    kind,
    input  logic signed [dq_pkg::WORD_W-1:0] value,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [dq_pkg::WORD_W-1:0] popped,
    output logic                             was_empty,
    output logic                             was_full,
    output logic [$clog2(DEPTH+1)-1:0]       count
);
    import dq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    logic [WORD_W-1:0] cell_data [DEPTH];
    logic [WORD_W-1:0] cell_tail [DEPTH];
    logic [DEPTH-1:0]  cell_valid;
    cell_cmd_t         cmd;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [WORD_W-1:0] popped_reg;
    logic [WORD_W-1:0] popped_next;
    logic              was_empty_reg;
    logic              was_empty_next;
    logic              was_full_reg;
    logic              was_full_next;

    logic              in_accept;
    logic              is_empty;
    logic              is_full;
    logic [WORD_W-1:0] rear_word;

    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == FULL_COUNT);

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic [WORD_W-1:0] left_data;
            logic              left_valid;
            logic [WORD_W-1:0] right_data;
            logic              right_valid;

            if (g == 0)
            begin : g_first
                // Ahead of the first cell stands the incoming word, always present.
                assign left_data  = value;
                assign left_valid = 1'b1;
            end
            else
            begin : g_inner_left
                assign left_data  = cell_data[g-1];
                assign left_valid = cell_valid[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_last
                assign right_data  = '0;
                assign right_valid = 1'b0;
            end
            else
            begin : g_inner_right
                assign right_data  = cell_data[g+1];
                assign right_valid = cell_valid[g+1];
            end

            dq_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cmd),
                .left_data   (left_data),
                .left_valid  (left_valid),
                .right_data  (right_data),
                .right_valid (right_valid),
                .data        (cell_data[g]),
                .valid       (cell_valid[g]),
                .tail_data   (cell_tail[g])
            );
        end
    endgenerate

    // At most one cell marks itself as the tail, so an OR picks its word.
    always_comb
    begin
        rear_word = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rear_word = rear_word | cell_tail[i];
        end
    end

    always_comb
    begin
        cmd.op         = CELL_HOLD;
        cmd.word       = value;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        popped_next    = popped_reg;
        was_empty_next = was_empty_reg;
        was_full_next  = was_full_reg;
        if (in_accept)
        begin
            out_valid_next = 1'b1;
            popped_next    = '0;
            was_empty_next = 1'b0;
            was_full_next  = 1'b0;
            unique case (kind)
                KIND_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        was_full_next = 1'b1;
                    end
                    else
                    begin
                        cmd.op     = CELL_SHIFT_BACK;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                KIND_PUSH_REAR:
                begin
                    if (is_full)
                    begin
                        was_full_next = 1'b1;
                    end
                    else
                    begin
                        cmd.op     = CELL_WRITE_TAIL;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                KIND_POP_FRONT:
                begin
                    if (is_empty)
                    begin
                        was_empty_next = 1'b1;
                    end
                    else
                    begin
                        cmd.op      = CELL_SHIFT_FORWARD;
                        popped_next = cell_data[0];
                        count_next  = count_reg - CNT_W'(1);
                    end
                end
                KIND_POP_REAR:
                begin
                    if (is_empty)
                    begin
                        was_empty_next = 1'b1;
                    end
                    else
                    begin
                        cmd.op      = CELL_DROP_TAIL;
                        popped_next = rear_word;
                        count_next  = count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        popped_reg    <= popped_next;
        was_empty_reg <= was_empty_next;
        was_full_reg  <= was_full_next;
    end

    assign out_valid = out_valid_reg;
    assign popped    = popped_reg;
    assign was_empty = was_empty_reg;
    assign was_full  = was_full_reg;
    assign count     = count_reg;

    // The occupied cells always match the element count.
    a_count_matches_cells : assert property (
        @(posedge clk) disable iff (!rst_n)
        $countones(cell_valid) == count_reg
    ) else $error("cell valid bits disagree with the element count");

    // Occupied cells form an unbroken run from the first cell.
    a_cells_packed : assert property (
        @(posedge clk) disable iff (!rst_n)
        ((cell_valid & (cell_valid + DEPTH'(1))) == '0)
    ) else $error("occupied cells are not packed at the front");

    // A pop that finds the queue empty reports it in the next result.
    a_empty_pop_flagged : assert property (
        @(posedge clk) disable iff (!rst_n)
        in_accept && is_empty && (kind == KIND_POP_FRONT || kind == KIND_POP_REAR)
        |=> out_valid && was_empty && (popped == '0)
    ) else $error("pop from an empty queue not flagged");

    // A push into a full queue leaves the count at its limit.
    a_full_push_rejected : assert property (
        @(posedge clk) disable iff (!rst_n)
        in_accept && is_full && (kind == KIND_PUSH_FRONT || kind == KIND_PUSH_REAR)
        |=> was_full && (count_reg == FULL_COUNT)
    ) else $error("push into a full queue not rejected");

endmodule
